@@ rtl/stsa_pkg.sv @@
// Package for the sparse transpose scatter accumulator.
// Holds field widths, stream packing widths, operation codes and FSM states.
// Depends on nothing; every other file imports it.
package stsa_pkg;

  // Default scratch depth: one column block of 16K entries
  localparam int BLOCK_COLUMNS_DEF = 16 * 1024;

  // Field widths
  localparam int IDX_W  = 14;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 48;
  localparam int PROD_W = 2 * VAL_W;
  localparam int FRAC_W = 16;

  // Stream packing: fields packed from bit 0 up, padded to whole bytes
  localparam int IN_FIELDS_W  = IDX_W + 2 * VAL_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = IDX_W + SUM_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Operation carried on in_tuser
  typedef enum logic {
    OP_ACC   = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // Control states of the top level
  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } state_t;

endpackage

@@ rtl/sparse_transpose_scatter_accumulator.sv @@
// Top level of the sparse transpose scatter accumulator.
// Instantiates stsa_scratch; depends on stsa_pkg.
//
// Scratchpad accumulator for one column block of a transposed sparse
// matrix-vector product, in Q16.16 / Q32.16 fixed point. An accumulate
// transfer (in_tuser = 0) multiplies row_value by matrix_value, rounds the
// product to Q32.16 (nearest, ties toward plus infinity) and adds it with
// saturation to the 48-bit entry picked by column_index. A drain transfer
// (in_tuser = 1) returns the entry on the output stream, flags it nonzero on
// out_tuser and clears it. Indices at or beyond BLOCK_COLUMNS are ignored by
// accumulates and drain as zero. After reset the block sweeps the scratch
// store to zero, one entry per cycle, and holds in_tready low until the sweep
// has covered all BLOCK_COLUMNS entries. Afterwards the multiplier runs in the
// accepting cycle, the scratch read lands in the next cycle, and the add,
// saturate and write back happen in that cycle, with a forwarding path so
// back-to-back updates of one entry are exact. Accumulates stream at one per
// cycle. A drain uses the single output register, so no transfer is taken
// while a drain sits in stage one, and none while a drained result is held by
// out_tready low.
module sparse_transpose_scatter_accumulator #(
  parameter int BLOCK_COLUMNS = stsa_pkg::BLOCK_COLUMNS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // column_index[13:0], row_value[45:14], matrix_value[77:46], zero pad
  input  logic [stsa_pkg::IN_DATA_W-1:0]      in_tdata,
  // op[0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // drained_index[13:0], drained_sum[61:14], zero pad
  output logic [stsa_pkg::OUT_DATA_W-1:0]     out_tdata,
  // was_nonzero[0]
  output logic                                out_tuser
);
  import stsa_pkg::*;

  localparam int ADDR_W = $clog2(BLOCK_COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BLOCK_COLUMNS - 1);
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Input unpacking
  logic [IDX_W-1:0]        in_col;
  logic signed [VAL_W-1:0] in_row;
  logic signed [VAL_W-1:0] in_mat;
  op_t                     in_op;
  logic                    in_fire;
  logic                    in_hit;
  logic signed [PROD_W-1:0] prod;

  assign in_col  = in_tdata[IDX_W-1:0];
  assign in_row  = signed'(in_tdata[IDX_W +: VAL_W]);
  assign in_mat  = signed'(in_tdata[IDX_W+VAL_W +: VAL_W]);
  assign in_op   = op_t'(in_tuser);
  assign in_fire = in_tvalid && in_tready;
  assign in_hit  = 32'(in_col) < 32'(BLOCK_COLUMNS);
  assign prod    = in_row * in_mat;

  // Clear sweep control
  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    clearing     = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clearing     = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        clr_addr_nxt = '0;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Stage one: item waiting for its scratch read
  logic                     s1_valid_r;
  op_t                      s1_op_r;
  logic [IDX_W-1:0]         s1_idx_r;
  logic                     s1_hit_r;
  logic signed [PROD_W-1:0] s1_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_op;
      s1_idx_r  <= in_col;
      s1_hit_r  <= in_hit;
      s1_prod_r <= prod;
    end
  end

  // Output register; a drain in stage one always finds it free
  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic signed [SUM_W-1:0] out_sum_r;
  logic                    out_nz_r;
  logic                    s1_drain;

  assign s1_drain = s1_valid_r && (s1_op_r == OP_DRAIN);

  // Accept only when a drain taken now can load the output register next cycle
  assign in_tready = (state_r == ST_RUN) && (!out_valid_r || out_tready) && !s1_drain;

  // Scratch store
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic signed [SUM_W-1:0] wr_data;
  logic signed [SUM_W-1:0] rd_data;
  logic [ADDR_W-1:0]       s1_addr;

  assign s1_addr = ADDR_W'(s1_idx_r);

  stsa_scratch #(
    .DEPTH  (BLOCK_COLUMNS),
    .ADDR_W (ADDR_W)
  ) u_scratch (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (ADDR_W'(in_col)),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Stage two: rescale, add, saturate, write back
  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] prod_q;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;

  assign base   = s1_hit_r ? rd_data : '0;
  // floor((p + 2^15) / 2^16) == (p >>> 16) + p[15]
  assign prod_q = s1_prod_r[FRAC_W +: SUM_W];
  assign sum_wide = {base[SUM_W-1], base} + {prod_q[SUM_W-1], prod_q}
                  + (SUM_W+1)'(s1_prod_r[FRAC_W-1]);

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else begin
      wr_en   = s1_valid_r && s1_hit_r;
      wr_addr = s1_addr;
      wr_data = (s1_op_r == OP_DRAIN) ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_drain) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_drain) begin
      out_idx_r <= s1_idx_r;
      out_sum_r <= base;
      out_nz_r  <= (base != '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_sum_r, out_idx_r});
  assign out_tuser  = out_nz_r;

endmodule

@@ rtl/stsa_scratch.sv @@
// Scratch store of partial sums: one write port, one registered read port.
// Forwards a write that lands on the entry read in the same cycle.
// Depends on stsa_pkg.
module stsa_scratch #(
  parameter int DEPTH  = stsa_pkg::BLOCK_COLUMNS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              rd_en,
  input  logic [ADDR_W-1:0]                 rd_addr,
  input  logic                              wr_en,
  input  logic [ADDR_W-1:0]                 wr_addr,
  input  logic signed [stsa_pkg::SUM_W-1:0] wr_data,
  output logic signed [stsa_pkg::SUM_W-1:0] rd_data
);
  import stsa_pkg::*;

  logic signed [SUM_W-1:0] mem [DEPTH];
  logic signed [SUM_W-1:0] rd_q_r;
  logic signed [SUM_W-1:0] fwd_data_r;
  logic                    fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // The array returns the old value on a same-cycle collision: take the new one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;

endmodule

@@ rtl/stsa_checker.sv @@
// Port-level checks for the sparse transpose scatter accumulator.
// Bound to the top level below; depends on stsa_pkg.
module stsa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [stsa_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser
);
  import stsa_pkg::*;

  // Hold a stalled result transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Flag nonzero exactly when the drained sum is nonzero
  a_nz_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == (out_tdata[IDX_W +: SUM_W] != '0))
    else $error("was_nonzero disagrees with drained_sum");

  // Hold off input after each reset cycle, as the store sweep begins
  a_clear_hold: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken during clear sweep");

  // Every accepted drain shows a result once it has left stage one
  a_drain_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |-> ##2 out_tvalid)
    else $error("drain produced no result");

  // Never take input while a result is stalled
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid || out_tready)
    else $error("input accepted while result stalled");

endmodule

bind sparse_transpose_scatter_accumulator stsa_checker u_stsa_checker (.*);

@@ dv/tb_top.sv @@
// Self-checking testbench for sparse_transpose_scatter_accumulator.
// Drives directed and random accumulate/drain transfers, predicts each drain in a local
// scratch model and compares results field by field. Depends on stsa_pkg and the RTL top.
module tb_top;
  import stsa_pkg::*;

  localparam int COLUMNS      = BLOCK_COLUMNS_DEF;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 8;

  localparam logic signed [PROD_W-1:0] SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [PROD_W-1:0] SUM_LO = -SUM_HI - 64'sd1;
  localparam logic [IDX_W-1:0]         IDX_TOP = '1;

  typedef struct {
    logic [IDX_W-1:0]        index;
    logic signed [SUM_W-1:0] sum;
    logic                    nonzero;
  } drain_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  // Random idling on both sides; cleared for full-rate stretches
  logic idling = 1'b1;
  // Bumped by a test to ask the receiver for one long hold-off
  int   hold_requests = 0;

  // Scratch model and the drains still owed by the block
  logic signed [SUM_W-1:0] col_sums [COLUMNS] = '{default: '0};
  drain_result_t           pending_drains [$];

  int n_acc     = 0;
  int n_drain   = 0;
  int n_nonzero = 0;
  int n_sat     = 0;
  int errors    = 0;

  sparse_transpose_scatter_accumulator #(
    .BLOCK_COLUMNS(COLUMNS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Full Q32.32 product, rounded to Q32.16: add half an LSB, then floor by
  // arithmetic shift. The result always fits the 48-bit sum width.
  function automatic logic signed [SUM_W-1:0] rescale_product(
    logic signed [VAL_W-1:0] a,
    logic signed [VAL_W-1:0] b
  );
    logic signed [PROD_W-1:0] wa;
    logic signed [PROD_W-1:0] wb;
    logic signed [PROD_W-1:0] p;
    wa = a;
    wb = b;
    p  = wa * wb;
    p  = p + (64'sd1 <<< (FRAC_W - 1));
    p  = p >>> FRAC_W;
    return p[SUM_W-1:0];
  endfunction

  // Apply one accepted transfer to the scratch model; queue the drain result.
  function automatic void apply_transfer(
    op_t                     op,
    logic [IDX_W-1:0]        idx,
    logic signed [VAL_W-1:0] row_value,
    logic signed [VAL_W-1:0] matrix_value
  );
    logic signed [PROD_W-1:0] acc;
    drain_result_t            res;
    if (op == OP_ACC) begin
      n_acc++;
      // Indices beyond the block leave the store untouched
      if (idx < COLUMNS) begin
        acc = col_sums[idx];
        acc = acc + rescale_product(row_value, matrix_value);
        if (acc > SUM_HI) begin
          acc = SUM_HI;
          n_sat++;
        end else if (acc < SUM_LO) begin
          acc = SUM_LO;
          n_sat++;
        end
        col_sums[idx] = acc[SUM_W-1:0];
      end
    end else begin
      n_drain++;
      res.index = idx;
      res.sum   = '0;
      if (idx < COLUMNS) begin
        res.sum       = col_sums[idx];
        col_sums[idx] = '0;
      end
      res.nonzero = (res.sum != 0);
      if (res.nonzero)
        n_nonzero++;
      pending_drains.push_back(res);
    end
  endfunction

  // Monitor both streams at the edge: values read here are the pre-edge ones.
  always @(posedge clk) begin
    drain_result_t           want;
    logic [IDX_W-1:0]        got_idx;
    logic signed [SUM_W-1:0] got_sum;
    if (rst_n && in_tvalid && in_tready)
      apply_transfer(op_t'(in_tuser), in_tdata[IDX_W-1:0], in_tdata[IDX_W +: VAL_W],
                     in_tdata[IDX_W+VAL_W +: VAL_W]);
    if (rst_n && out_tvalid && out_tready) begin
      got_idx = out_tdata[IDX_W-1:0];
      got_sum = out_tdata[IDX_W +: SUM_W];
      if (pending_drains.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: index %0d sum %0d flag %0b",
                 $time, got_idx, got_sum, out_tuser);
      end else begin
        want = pending_drains.pop_front();
        if (got_idx !== want.index) begin
          errors++;
          $display("%0t: drained_index mismatch: expected %0d, actual %0d",
                   $time, want.index, got_idx);
        end
        if (got_sum !== want.sum) begin
          errors++;
          $display("%0t: drained_sum mismatch at index %0d: expected %0d, actual %0d",
                   $time, want.index, want.sum, got_sum);
        end
        if (out_tuser !== want.nonzero) begin
          errors++;
          $display("%0t: was_nonzero mismatch at index %0d: expected %0b, actual %0b",
                   $time, want.index, want.nonzero, out_tuser);
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request, counted here.
  always @(posedge clk) begin
    int holds_served;
    int hold_left;
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else
      out_tready <= !(idling && $urandom_range(99) < 8);
  end

  // Watchdog: the slowest correct run, clearing sweep included, is far below this.
  always @(posedge clk) begin
    int unsigned cycle_count;
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d drains pending",
               cycle_count, pending_drains.size());
      $display("FAIL");
      $finish;
    end
  end

  // Offer one transfer and hold it until accepted. Call just after a rising edge.
  task automatic send_item(
    op_t                     op,
    logic [IDX_W-1:0]        idx,
    logic signed [VAL_W-1:0] row_value,
    logic signed [VAL_W-1:0] matrix_value
  );
    logic [IN_DATA_W-1:0] word;
    word                          = '0;
    word[IDX_W-1:0]               = idx;
    word[IDX_W +: VAL_W]          = row_value;
    word[IDX_W+VAL_W +: VAL_W]    = matrix_value;
    // Drop valid for a random gap first, so gaps land on every phase
    while (idling && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    do
      @(posedge clk);
    while (!in_tready);
  endtask

  // Drop valid and wait until every drain has come back, then let the pipe settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_drains.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      // Within +/-8.0, so sums grow without clamping straight away
      1: return int'($urandom_range(1048575)) - 524288;
      2: return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      default: return int'($urandom_range(131071)) - 65536;
    endcase
  endfunction

  // Offered during the clearing sweep; each drained entry must read back as zero.
  task automatic test_cleared_after_reset();
    send_item(OP_DRAIN, '0, 32'sd0, 32'sd0);
    send_item(OP_DRAIN, IDX_TOP, 32'sd0, 32'sd0);
    send_item(OP_DRAIN, 14'h2000, 32'sd0, 32'sd0);
    send_item(OP_DRAIN, IDX_W'($urandom), 32'sd0, 32'sd0);
    wait_drained();
  endtask

  task automatic test_rounding_and_saturation();
    // Ties round towards plus infinity: +0.5 LSB up to 1, -0.5 LSB up to 0
    send_item(OP_ACC, 14'd7, 32'sd1, 32'sh0000_8000);
    send_item(OP_DRAIN, 14'd7, 32'sd0, 32'sd0);
    send_item(OP_ACC, 14'd8, -32'sd1, 32'sh0000_8000);
    send_item(OP_DRAIN, 14'd8, 32'sd0, 32'sd0);
    send_item(OP_ACC, 14'd9, -32'sd1, 32'sh0000_8001);
    send_item(OP_DRAIN, 14'd9, 32'sd0, 32'sd0);
    // Top index: back-to-back largest products run past the upper limit
    repeat (3) send_item(OP_ACC, IDX_TOP, 32'sh8000_0000, 32'sh8000_0000);
    send_item(OP_DRAIN, IDX_TOP, 32'sd0, 32'sd0);
    send_item(OP_DRAIN, IDX_TOP, 32'sd0, 32'sd0);
    // Index zero: clamp at the lower limit, then climb back off it
    repeat (3) send_item(OP_ACC, '0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_item(OP_ACC, '0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_item(OP_DRAIN, '0, 32'sd0, 32'sd0);
    // Drain with both value fields all ones: the values must be ignored
    send_item(OP_ACC, 14'h2AAA, 32'sh7FFF_FFFF, -32'sd1);
    send_item(OP_DRAIN, 14'h2AAA, -32'sd1, -32'sd1);
    send_item(OP_ACC, 14'h1555, 32'sh0001_0000, 32'sh0001_0000);
    send_item(OP_DRAIN, 14'h1555, 32'sd0, 32'sd0);
    wait_drained();
  endtask

  // Hold the output off for a long stretch while drains keep coming, so the
  // output register fills and the input stalls behind it.
  task automatic test_output_hold();
    logic [IDX_W-1:0] idx;
    idling = 1'b1;
    hold_requests++;
    repeat (40) begin
      idx = IDX_W'($urandom_range(15));
      send_item(OP_ACC, idx, pick_value(), pick_value());
      send_item(OP_DRAIN, idx, 32'sd0, 32'sd0);
    end
    wait_drained();
  endtask

  // Bursts on a small set of live entries, so drains mostly return real sums
  // and same-entry updates land back to back; a share of noise goes anywhere.
  task automatic test_random_traffic(int n_items);
    logic [IDX_W-1:0] pool [6];
    logic [IDX_W-1:0] idx;
    op_t              op;
    int               sent;
    int               burst;
    sent   = 0;
    idling = 1'b0;
    while (sent < n_items) begin
      foreach (pool[i])
        pool[i] = IDX_W'($urandom);
      burst = $urandom_range(30, 8);
      repeat (burst) begin
        // Open with a full-rate stretch, then idle at random
        if (sent == 150)
          idling = 1'b1;
        if ($urandom_range(99) < 85) begin
          op  = ($urandom_range(99) < 25) ? OP_DRAIN : OP_ACC;
          idx = pool[$urandom_range(5)];
        end else begin
          op  = op_t'($urandom_range(1));
          idx = IDX_W'($urandom);
        end
        send_item(op, idx, pick_value(), pick_value());
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_cleared_after_reset();
    test_rounding_and_saturation();
    test_output_hold();
    test_random_traffic(450);
    if (pending_drains.size() != 0) begin
      errors++;
      $display("%0t: %0d drain results never arrived", $time, pending_drains.size());
    end
    $display("Covered %0d accumulates and %0d drains (%0d nonzero), %0d clamped sums, %0d errors",
             n_acc, n_drain, n_nonzero, n_sat, errors);
    $display("Included rounding ties, both clamp limits and a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/stsa_pkg.sv
rtl/stsa_scratch.sv
rtl/sparse_transpose_scatter_accumulator.sv
rtl/stsa_checker.sv
dv/tb_top.sv
